FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on a rising edge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ktab_pkg.sv
// ---------------------------------------------------------------------------
// ktab_pkg
// Field widths, operation codes and status codes of the keyed table.
// ---------------------------------------------------------------------------
`default_nettype none

package ktab_pkg;

	localparam int OP_W   = 2;
	localparam int KEY_W  = 32;
	localparam int AMT_W  = 32;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LIST   = 2'd1,
		OP_UPDATE = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_DUP       = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/ktab_if.sv
// ---------------------------------------------------------------------------
// ktab_req_if / ktab_rsp_if
// Valid/ready channels for requests into and results out of the table.
// ---------------------------------------------------------------------------
`default_nettype none

interface ktab_req_if
	import ktab_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [KEY_W-1:0]  key;
	logic signed [AMT_W-1:0]  amount;

	modport source (output valid, output op, output key, output amount, input ready);
	modport sink   (input valid, input op, input key, input amount, output ready);
endinterface

interface ktab_rsp_if
	import ktab_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [KEY_W-1:0]  entry_key;
	logic signed [AMT_W-1:0]  entry_amount;
	logic [CNT_W-1:0]         entry_count;
	logic                     last;

	modport source (output valid, output status, output entry_key, output entry_amount,
		output entry_count, output last, input ready);
	modport sink   (input valid, input status, input entry_key, input entry_amount,
		input entry_count, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/keyed_table_insert_update_remove_core.sv
// Insert and update scan the entries in order; a remove that finds its key then shifts
// every entry after it one place down. The scan stops at the match and the shift covers
// only the rest. List reads one entry in S_LRD, then gives its result in S_LEMIT.
// Scan, shift and list are paced by the single read port of the entry memory,
// which they share. One item at a time.
// Reset clears the entry count and the control state; the entry memory is not cleared.
// ---------------------------------------------------------------------------
// keyed_table_insert_update_remove_core
// Key/quantity table in insertion order with linear search and compaction.
// ---------------------------------------------------------------------------
`default_nettype none

module keyed_table_insert_update_remove_core
	import ktab_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	ktab_req_if.sink    req,
	ktab_rsp_if.source  rsp
);

	`include "assert_macros.svh"

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_SHIFT = 6'b000100,
		S_EMIT  = 6'b001000,
		S_LRD   = 6'b010000,
		S_LEMIT = 6'b100000
	} state_t;

	// Entry memory, one read and one write port each.
	logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic signed [AMT_W-1:0] amt_mem [TABLE_DEPTH];
	logic signed [KEY_W-1:0] rd_key_q;
	logic signed [AMT_W-1:0] rd_amt_q;
	logic [AW-1:0]           rd_addr;
	logic [AW-1:0]           wr_addr;
	logic                    key_we, amt_we;
	logic signed [KEY_W-1:0] wr_key;
	logic signed [AMT_W-1:0] wr_amt;

	// Control state.
	state_t         state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  idx_q, idx_d;
	logic           pend_q, pend_d;
	logic           o_vld_q, o_vld_d;

	// Item and result payload.
	op_t                     op_q, op_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic signed [AMT_W-1:0] amt_q, amt_d;
	logic [AW-1:0]           cmp_idx_q, cmp_idx_d;
	status_t                 res_status_q, res_status_d;
	status_t                 o_status_q;
	logic signed [KEY_W-1:0] o_key_q;
	logic signed [AMT_W-1:0] o_amt_q;
	logic [CNT_W-1:0]        o_count_q;
	logic                    o_last_q;

	logic                    emit_en;
	status_t                 emit_status;
	logic signed [KEY_W-1:0] emit_key;
	logic signed [AMT_W-1:0] emit_amt;
	logic                    emit_last;

	logic           slot_free, hit, idx_lt;
	logic [CW-1:0]  idx_inc, idx_dec;

	assign slot_free = !o_vld_q || rsp.ready;
	assign hit       = pend_q && (rd_key_q == key_q);
	assign idx_lt    = idx_q < count_q;
	assign idx_inc   = idx_q + CW'(1);
	assign idx_dec   = idx_q - CW'(1);
	assign rd_addr   = idx_q[AW-1:0];

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = o_vld_q;
	assign rsp.status       = o_status_q;
	assign rsp.entry_key    = o_key_q;
	assign rsp.entry_amount = o_amt_q;
	assign rsp.entry_count  = o_count_q;
	assign rsp.last         = o_last_q;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		pend_d       = pend_q;
		op_d         = op_q;
		key_d        = key_q;
		amt_d        = amt_q;
		cmp_idx_d    = cmp_idx_q;
		res_status_d = res_status_q;
		key_we       = 1'b0;
		amt_we       = 1'b0;
		wr_addr      = cmp_idx_q;
		wr_key       = key_q;
		wr_amt       = amt_q;
		emit_en      = 1'b0;
		emit_status  = res_status_q;
		emit_key     = key_q;
		emit_amt     = '0;
		emit_last    = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d   = op_t'(req.op);
					key_d  = req.key;
					amt_d  = req.amount;
					idx_d  = '0;
					pend_d = 1'b0;
					case (op_t'(req.op))
						OP_LIST: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_EMIT;
							end else begin
								state_d = S_LRD;
							end
						end
						OP_INSERT: begin
							if (count_q >= DEPTH_C) begin
								res_status_d = ST_FULL;
								state_d      = S_EMIT;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							state_d = S_SCAN;
						end
					endcase
				end
			end

			// Reads are issued one entry ahead of the compare.
			S_SCAN: begin
				if (hit) begin
					case (op_q)
						OP_INSERT: begin
							res_status_d = ST_DUP;
							state_d      = S_EMIT;
						end
						OP_UPDATE: begin
							amt_we       = 1'b1;
							res_status_d = ST_OK;
							state_d      = S_EMIT;
						end
						default: begin
							idx_d   = CW'(cmp_idx_q) + CW'(1);
							pend_d  = 1'b0;
							state_d = S_SHIFT;
						end
					endcase
				end else if (idx_lt) begin
					cmp_idx_d = idx_q[AW-1:0];
					idx_d     = idx_inc;
					pend_d    = 1'b1;
				end else begin
					if (op_q == OP_INSERT) begin
						key_we       = 1'b1;
						amt_we       = 1'b1;
						wr_addr      = count_q[AW-1:0];
						count_d      = count_q + CW'(1);
						res_status_d = ST_OK;
					end else begin
						res_status_d = ST_NOT_FOUND;
					end
					state_d = S_EMIT;
				end
			end

			// Entry idx is read while the entry read in the previous cycle lands one place down.
			S_SHIFT: begin
				if (pend_q) begin
					key_we  = 1'b1;
					amt_we  = 1'b1;
					wr_addr = cmp_idx_q;
					wr_key  = rd_key_q;
					wr_amt  = rd_amt_q;
				end
				if (idx_lt) begin
					cmp_idx_d = idx_dec[AW-1:0];
					idx_d     = idx_inc;
					pend_d    = 1'b1;
				end else begin
					pend_d       = 1'b0;
					count_d      = count_q - CW'(1);
					res_status_d = ST_OK;
					state_d      = S_EMIT;
				end
			end

			S_EMIT: begin
				if (slot_free) begin
					emit_en  = 1'b1;
					emit_key = (res_status_q == ST_EMPTY) ? '0 : key_q;
					state_d  = S_IDLE;
				end
			end

			S_LRD: begin
				state_d = S_LEMIT;
			end

			S_LEMIT: begin
				if (slot_free) begin
					emit_en     = 1'b1;
					emit_status = ST_OK;
					emit_key    = rd_key_q;
					emit_amt    = rd_amt_q;
					emit_last   = (idx_inc == count_q);
					if (idx_inc == count_q) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_inc;
						state_d = S_LRD;
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		o_vld_d = emit_en ? 1'b1 : (rsp.ready ? 1'b0 : o_vld_q);
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (amt_we) begin
			amt_mem[wr_addr] <= wr_amt;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_amt_q <= amt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			o_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			pend_q  <= pend_d;
			o_vld_q <= o_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		key_q        <= key_d;
		amt_q        <= amt_d;
		cmp_idx_q    <= cmp_idx_d;
		res_status_q <= res_status_d;
		if (emit_en) begin
			o_status_q <= emit_status;
			o_key_q    <= emit_key;
			o_amt_q    <= emit_amt;
			o_count_q  <= CNT_W'(count_q);
			o_last_q   <= emit_last;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= DEPTH_C,
		"entry count exceeds table depth")

	`ASSERT_ALWAYS(a_shift_bound, clk, arst_n, (state_q != S_SHIFT) || (idx_q <= count_q),
		"shift source ran past the last entry")

	`ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1,
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1))
		|| (count_q + CW'(1) == $past(count_q)),
		"entry count moved by more than one")

endmodule

`default_nettype wire

FILE: verif/keyed_table_insert_update_remove_core_test.sv
// ---------------------------------------------------------------------------
// keyed_table_insert_update_remove_core_test
// Self-checking testbench for the keyed table. A directed table of items covers
// the extremes of keys and quantities, every operation and each refusal but a
// full table. Next the table is filled to capacity. Random items then follow on
// a small key pool so that searches hit often. Results are compared with typed
// directed rows or a behavioral copy of the table. Both channels stall at random.
// ---------------------------------------------------------------------------

module keyed_table_insert_update_remove_core_test;
	import ktab_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 64;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 2 * DEPTH + 8;
	// The limit leaves ample room for the slowest correct run: about 170 items,
	// some of them lists of a full table, with every result stalled at random
	// and one long hold on the receiver.
	localparam int LIMIT_CYCLES = 400000;
	localparam int POOL_SIZE    = 16;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] key;
		logic signed [AMT_W-1:0] amount;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} table_rsp_t;

	typedef struct packed {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
		logic signed [AMT_W-1:0] amount;
		logic                    typed;
		status_t                 status;
		logic [CNT_W-1:0]        count;
	} dir_row_t;

	logic clk;
	logic arst_n;

	ktab_req_if req_ch();
	ktab_rsp_if rsp_ch();

	keyed_table_insert_update_remove_core #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Behavioral copy of the table.
	logic signed [KEY_W-1:0] tab_key [DEPTH];
	logic signed [AMT_W-1:0] tab_amt [DEPTH];
	int unsigned             tab_used;

	table_rsp_t rsp_expected [$];

	int idle_pct      = 18;
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int err_count     = 0;
	int cycle_count   = 0;
	int items_sent    = 0;
	int lists_sent    = 0;
	int full_refusals = 0;
	int results_seen  = 0;

	logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
	dir_row_t                dir_rows [22];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, rsp_expected.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int unsigned find_slot(logic signed [KEY_W-1:0] key);
		for (int unsigned i = 0; i < tab_used; i++) begin
			if (tab_key[i] == key)
				return i;
		end
		return tab_used;
	endfunction

	function automatic void push_result(status_t st, logic signed [KEY_W-1:0] key,
		logic signed [AMT_W-1:0] amount, logic last);
		table_rsp_t r;
		r.status = st;
		r.key    = key;
		r.amount = amount;
		r.count  = tab_used[CNT_W-1:0];
		r.last   = last;
		rsp_expected.push_back(r);
	endfunction

	// Applies one accepted item to the table copy; queues its results when asked.
	function automatic void apply_op(op_t op, logic signed [KEY_W-1:0] key,
		logic signed [AMT_W-1:0] amount, bit record);
		int unsigned pos;
		status_t     st;
		pos = find_slot(key);
		case (op)
			OP_INSERT: begin
				if (tab_used >= DEPTH) begin
					st = ST_FULL;
					full_refusals++;
				end else if (pos < tab_used) begin
					st = ST_DUP;
				end else begin
					tab_key[tab_used] = key;
					tab_amt[tab_used] = amount;
					tab_used++;
					st = ST_OK;
				end
				if (record)
					push_result(st, key, '0, 1'b1);
			end
			OP_LIST: begin
				if (!record) begin
				end else if (tab_used == 0) begin
					push_result(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (int unsigned i = 0; i < tab_used; i++)
						push_result(ST_OK, tab_key[i], tab_amt[i], i + 1 == tab_used);
				end
			end
			OP_UPDATE: begin
				if (pos < tab_used) begin
					tab_amt[pos] = amount;
					st = ST_OK;
				end else begin
					st = ST_NOT_FOUND;
				end
				if (record)
					push_result(st, key, '0, 1'b1);
			end
			default: begin
				if (pos < tab_used) begin
					for (int unsigned i = pos; i + 1 < tab_used; i++) begin
						tab_key[i] = tab_key[i + 1];
						tab_amt[i] = tab_amt[i + 1];
					end
					tab_used--;
					st = ST_OK;
				end else begin
					st = ST_NOT_FOUND;
				end
				if (record)
					push_result(st, key, '0, 1'b1);
			end
		endcase
	endfunction

	// Drives one item from a falling edge until it is accepted, then predicts it.
	task automatic offer_item(op_t op, logic signed [KEY_W-1:0] key,
		logic signed [AMT_W-1:0] amount, bit record);
		@(negedge clk);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid  = 1'b1;
		req_ch.op     = op;
		req_ch.key    = key;
		req_ch.amount = amount;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		items_sent++;
		if (op == OP_LIST)
			lists_sent++;
		apply_op(op, key, amount, record);
	endtask

	task automatic wait_drained();
		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Update and remove mostly aim at keys present in the table.
	function automatic logic signed [KEY_W-1:0] pick_key(bit prefer_table);
		if (prefer_table && tab_used > 0 && $urandom_range(1) == 1)
			return tab_key[$urandom_range(tab_used - 1)];
		if ($urandom_range(4) == 0)
			return $urandom;
		return key_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	task automatic random_items(int count, int remove_bias);
		int                      r;
		op_t                     op;
		logic signed [KEY_W-1:0] key;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 35 - remove_bias)
				op = OP_INSERT;
			else if (r < 48 - remove_bias)
				op = OP_LIST;
			else if (r < 70 - remove_bias)
				op = OP_UPDATE;
			else
				op = OP_REMOVE;
			key = pick_key(op != OP_INSERT);
			offer_item(op, key, $urandom, 1'b1);
		end
	endtask

	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready = 1'b0;
		end else begin
			rsp_ch.ready = (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		table_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen++;
			if (rsp_expected.size() == 0) begin
				$error("result with nothing expected: status %0d key %0d",
					rsp_ch.status, rsp_ch.entry_key);
				err_count++;
			end else begin
				want = rsp_expected.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.entry_key !== want.key) begin
					$error("entry_key: expected %0d, got %0d", want.key, rsp_ch.entry_key);
					err_count++;
				end
				if (rsp_ch.entry_amount !== want.amount) begin
					$error("entry_amount: expected %0d, got %0d", want.amount,
						rsp_ch.entry_amount);
					err_count++;
				end
				if (rsp_ch.entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count,
						rsp_ch.entry_count);
					err_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_ch.last);
					err_count++;
				end
			end
		end
	end

	initial begin
		logic signed [KEY_W-1:0] fresh;
		table_rsp_t              typed_rsp;

		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.op     = OP_INSERT;
		req_ch.key    = '0;
		req_ch.amount = '0;
		rsp_ch.ready  = 1'b0;
		tab_used      = 0;

		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7FFF_FFFF;
		key_pool[2] = 32'sh0000_0000;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// Rows with a typed result carry their status and count; the rest
		// are checked against the table copy.
		dir_rows = '{
			'{OP_LIST,   32'sh0000_0000, 32'sh0000_0000, 1'b1, ST_EMPTY,     7'd0},
			'{OP_UPDATE, 32'sh0000_0005, 32'sh0000_0009, 1'b1, ST_NOT_FOUND, 7'd0},
			'{OP_REMOVE, 32'sh0000_0005, 32'sh0000_0000, 1'b1, ST_NOT_FOUND, 7'd0},
			'{OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, ST_OK,        7'd1},
			'{OP_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, ST_OK,        7'd2},
			'{OP_INSERT, 32'sh0000_0000, 32'sh0000_0000, 1'b1, ST_OK,        7'd3},
			'{OP_INSERT, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, ST_OK,        7'd4},
			'{OP_INSERT, 32'sh7FFF_FFFF, 32'sh0000_0001, 1'b1, ST_DUP,       7'd4},
			'{OP_LIST,   32'sh1234_5678, 32'sh0000_0000, 1'b0, ST_OK,        7'd0},
			'{OP_UPDATE, 32'sh8000_0000, 32'sh8000_0000, 1'b1, ST_OK,        7'd4},
			'{OP_UPDATE, 32'sh0000_0001, 32'sh0000_0007, 1'b1, ST_NOT_FOUND, 7'd4},
			'{OP_REMOVE, 32'sh8000_0000, 32'sh0000_0000, 1'b1, ST_OK,        7'd3},
			'{OP_LIST,   32'sh0000_0000, 32'sh0000_0000, 1'b0, ST_OK,        7'd0},
			'{OP_REMOVE, 32'shFFFF_FFFF, 32'sh0000_0000, 1'b1, ST_OK,        7'd2},
			'{OP_INSERT, 32'sh8000_0000, 32'sh0000_002A, 1'b1, ST_OK,        7'd3},
			'{OP_REMOVE, 32'sh0000_0000, 32'sh0000_0000, 1'b1, ST_OK,        7'd2},
			'{OP_LIST,   32'sh0000_0000, 32'sh0000_0000, 1'b0, ST_OK,        7'd0},
			'{OP_REMOVE, 32'sh0000_0003, 32'sh0000_0000, 1'b1, ST_NOT_FOUND, 7'd2},
			'{OP_REMOVE, 32'sh7FFF_FFFF, 32'sh0000_0000, 1'b1, ST_OK,        7'd1},
			'{OP_REMOVE, 32'sh8000_0000, 32'sh0000_0000, 1'b1, ST_OK,        7'd0},
			'{OP_LIST,   32'sh0000_0000, 32'sh0000_0000, 1'b1, ST_EMPTY,     7'd0},
			'{OP_REMOVE, 32'sh8000_0000, 32'sh0000_0000, 1'b1, ST_NOT_FOUND, 7'd0}
		};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			offer_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].amount,
				!dir_rows[i].typed);
			if (dir_rows[i].typed) begin
				typed_rsp.status = dir_rows[i].status;
				typed_rsp.key    = dir_rows[i].key;
				typed_rsp.amount = '0;
				typed_rsp.count  = dir_rows[i].count;
				typed_rsp.last   = 1'b1;
				rsp_expected.push_back(typed_rsp);
			end
		end

		// Fill to capacity with fresh keys, with a duplicate attempt now and then.
		while (tab_used < DEPTH) begin
			if (tab_used > 0 && $urandom_range(9) == 0) begin
				offer_item(OP_INSERT, tab_key[$urandom_range(tab_used - 1)], $urandom, 1'b1);
			end else begin
				do
					fresh = $urandom;
				while (find_slot(fresh) < tab_used);
				offer_item(OP_INSERT, fresh, $urandom, 1'b1);
			end
		end
		// A full table refuses as full even when the key is present.
		offer_item(OP_INSERT, tab_key[0], $urandom, 1'b1);
		offer_item(OP_INSERT, key_pool[5], $urandom, 1'b1);
		offer_item(OP_LIST, '0, '0, 1'b1);
		offer_item(OP_UPDATE, tab_key[DEPTH - 1], 32'sh7FFF_FFFF, 1'b1);
		offer_item(OP_REMOVE, tab_key[0], '0, 1'b1);
		offer_item(OP_INSERT, key_pool[1], 32'sh8000_0000, 1'b1);
		offer_item(OP_LIST, '0, '0, 1'b1);

		random_items(25, 0);

		// The sender waits for every result, then runs with no idling while
		// the receiver holds off and the block backs up.
		@(negedge clk);
		req_ch.valid = 1'b0;
		wait_drained();
		idle_pct = 0;
		hold_requests++;
		offer_item(OP_LIST, '0, '0, 1'b1);
		random_items(20, 0);

		idle_pct = 18;
		random_items(30, 20);

		@(negedge clk);
		req_ch.valid = 1'b0;
		wait_drained();

		$display("Run covered %0d items, %0d of them lists, with %0d full-table refusals.",
			items_sent, lists_sent, full_refusals);
		$display("%0d results checked; %0d mismatches.", results_seen, err_count);
		if (err_count == 0 && rsp_expected.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
